@@ hdl/cds_pkg.sv @@
// Shared constants, register codes and field widths for the curl/divergence stencil.
`timescale 1ns / 1ps

package cds_pkg;

  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int COL_BITS       = 10;
  localparam int ROW_BITS       = 16;
  localparam int FW_BITS        = 11;
  localparam int FH_BITS        = 16;
  localparam int CFG_ADDR_BITS  = 4;
  localparam int CFG_DATA_BITS  = 32;
  localparam int REG_IDX_BITS   = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd2;

  localparam logic MODE_CURL = 1'b0;
  localparam logic MODE_DIV  = 1'b1;

  localparam logic [FW_BITS-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_BITS-1:0] FH_RESET = 16'd1024;

endpackage

@@ hdl/cds_if.sv @@
// Stream interfaces for the sample input channel and the result output channel.
`timescale 1ns / 1ps

interface cds_in_if import cds_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] a_value;
  logic signed [SAMPLE_BITS-1:0] b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink (input valid, input a_value, input b_value, output ready);
endinterface

interface cds_out_if import cds_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS+1:0]   result_value;
  logic        [COL_BITS-1:0]      result_col;
  logic        [ROW_BITS-1:0]      result_row;
  logic                            frame_last;

  modport source (output valid, output result_value, output result_col,
                  output result_row, output frame_last, input ready);
  modport sink (input valid, input result_value, input result_col,
                input result_row, input frame_last, output ready);
endinterface

@@ hdl/curl_divergence_stencil.sv @@
// Forward-difference curl and divergence over a raster stream, with line stores.
// Result words are written into a registered result queue as their input is accepted.
// Throughput: one input word per cycle while the result queue has room; a last-row
// word with a row above gives two result words; the single output port sets the rate.
// Input ready drops for one cycle after each register write while the stores are reread.
// Reset is synchronous, active low; line stores are not cleared and hold no valid state.
`timescale 1ns / 1ps

module curl_divergence_stencil import cds_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  cds_in_if.sink                   in_s,
  cds_out_if.source                out_s,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int RB    = SAMPLE_BITS + 2;
  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WB    = (AW + 1 > FW_BITS) ? AW + 1 : FW_BITS;
  localparam int DEPTH = 4;
  localparam int PW    = 2;
  localparam int CW    = 3;

  // Configuration registers.
  logic                mode_r;
  logic [FW_BITS-1:0]  fwidth_r;
  logic [FH_BITS-1:0]  fheight_r;
  logic                cfg_hold_r;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_CURL;
      fwidth_r   <= FW_RESET;
      fheight_r  <= FH_RESET;
      cfg_hold_r <= 1'b0;
    end else begin
      cfg_hold_r <= cfg_we;
      if (cfg_we) begin
        case (paddr[3:2])
          REG_MODE:   mode_r    <= pwdata[0];
          REG_WIDTH:  fwidth_r  <= pwdata[FW_BITS-1:0];
          REG_HEIGHT: fheight_r <= pwdata[FH_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = CFG_DATA_BITS'(mode_r);
      REG_WIDTH:  prdata = CFG_DATA_BITS'(fwidth_r);
      REG_HEIGHT: prdata = CFG_DATA_BITS'(fheight_r);
      default:    prdata = '0;
    endcase
  end

  // Effective frame size.
  logic [WB-1:0]       fw_ext;
  logic [WB-1:0]       w_eff;
  logic [WB-1:0]       wlast_full;
  logic [AW-1:0]       wlast;
  logic [ROW_BITS-1:0] hlast;

  always_comb begin
    fw_ext = WB'(fwidth_r);
    if (fw_ext == '0) begin
      w_eff = WB'(1);
    end else if (fw_ext > WB'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    wlast_full = w_eff - WB'(1);
    wlast      = wlast_full[AW-1:0];
    hlast      = (fheight_r == '0) ? '0 : fheight_r - ROW_BITS'(1);
  end

  // Position counters.
  logic [AW-1:0]       col_r;
  logic [ROW_BITS-1:0] row_r;
  logic [AW-1:0]       x;
  logic [ROW_BITS-1:0] y;
  logic                last_col;
  logic                last_row;
  logic                in_acc;

  assign x        = (col_r > wlast) ? wlast : col_r;
  assign y        = (row_r > hlast) ? hlast : row_r;
  assign last_col = (x == wlast);
  assign last_row = (y == hlast);

  // Result queue.
  logic signed [RB-1:0]   q_val_r  [DEPTH];
  logic [COL_BITS-1:0]    q_col_r  [DEPTH];
  logic [ROW_BITS-1:0]    q_row_r  [DEPTH];
  logic                   q_last_r [DEPTH];
  logic [PW-1:0]          wr_ptr_r;
  logic [PW-1:0]          rd_ptr_r;
  logic [CW-1:0]          q_cnt_r;
  logic                   out_pop;

  assign in_s.ready = (q_cnt_r <= CW'(DEPTH - 2)) && !cfg_hold_r;
  assign in_acc     = in_s.valid && in_s.ready;
  assign out_pop    = out_s.valid && out_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : y + ROW_BITS'(1);
      end else begin
        col_r <= x + AW'(1);
        row_r <= y;
      end
    end
  end

  // Line stores with two registered read ports and write bypass.
  logic signed [SB-1:0] a_store_r [MAX_WIDTH];
  logic signed [SB-1:0] b_store_r [MAX_WIDTH];
  logic signed [SB-1:0] cur_a_r;
  logic signed [SB-1:0] cur_b_r;
  logic signed [SB-1:0] nxt_a_r;
  logic signed [SB-1:0] nxt_b_r;
  logic [AW-1:0]        rd0_addr;
  logic [AW-1:0]        rd1_addr;

  always_comb begin
    if (in_acc) begin
      rd0_addr = last_col ? '0 : x + AW'(1);
    end else begin
      rd0_addr = x;
    end
    rd1_addr = (rd0_addr == wlast) ? rd0_addr : rd0_addr + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_store_r[x] <= in_s.a_value;
      b_store_r[x] <= in_s.b_value;
    end
    if (in_acc && rd0_addr == x) begin
      cur_a_r <= in_s.a_value;
      cur_b_r <= in_s.b_value;
    end else begin
      cur_a_r <= a_store_r[rd0_addr];
      cur_b_r <= b_store_r[rd0_addr];
    end
    if (in_acc && rd1_addr == x) begin
      nxt_a_r <= in_s.a_value;
      nxt_b_r <= in_s.b_value;
    end else begin
      nxt_a_r <= a_store_r[rd1_addr];
      nxt_b_r <= b_store_r[rd1_addr];
    end
  end

  // Stencil arithmetic.
  logic signed [RB-1:0]       ax;
  logic signed [RB-1:0]       ax1;
  logic signed [RB-1:0]       bx;
  logic signed [RB-1:0]       bx1;
  logic signed [RB-1:0]       ain;
  logic signed [RB-1:0]       bin;
  logic signed [RB-1:0]       above_val;
  logic signed [RB-1:0]       pass_val;
  logic [COL_BITS+AW-1:0]     col_ext;
  logic [COL_BITS-1:0]        res_col;
  logic                       e0_vld;
  logic                       e1_vld;

  always_comb begin
    ax  = $signed({{2{cur_a_r[SB-1]}}, cur_a_r});
    ax1 = $signed({{2{nxt_a_r[SB-1]}}, nxt_a_r});
    bx  = $signed({{2{cur_b_r[SB-1]}}, cur_b_r});
    bx1 = $signed({{2{nxt_b_r[SB-1]}}, nxt_b_r});
    ain = $signed({{2{in_s.a_value[SB-1]}}, in_s.a_value});
    bin = $signed({{2{in_s.b_value[SB-1]}}, in_s.b_value});
    if (last_col) begin
      above_val = ax;
    end else if (mode_r == MODE_CURL) begin
      above_val = (bx - bx1) - (ax - ain);
    end else begin
      above_val = (ax - ax1) + (bx - bin);
    end
    pass_val = ain;
    col_ext  = {{COL_BITS{1'b0}}, x};
    res_col  = col_ext[COL_BITS-1:0];
    e0_vld   = in_acc && (y != '0);
    e1_vld   = in_acc && last_row;
  end

  always_ff @(posedge clk) begin
    if (e0_vld) begin
      q_val_r[wr_ptr_r]  <= above_val;
      q_col_r[wr_ptr_r]  <= res_col;
      q_row_r[wr_ptr_r]  <= y - ROW_BITS'(1);
      q_last_r[wr_ptr_r] <= 1'b0;
      if (e1_vld) begin
        q_val_r[wr_ptr_r + PW'(1)]  <= pass_val;
        q_col_r[wr_ptr_r + PW'(1)]  <= res_col;
        q_row_r[wr_ptr_r + PW'(1)]  <= y;
        q_last_r[wr_ptr_r + PW'(1)] <= last_col;
      end
    end else if (e1_vld) begin
      q_val_r[wr_ptr_r]  <= pass_val;
      q_col_r[wr_ptr_r]  <= res_col;
      q_row_r[wr_ptr_r]  <= y;
      q_last_r[wr_ptr_r] <= last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(e0_vld) + PW'(e1_vld);
      rd_ptr_r <= rd_ptr_r + PW'(out_pop);
      q_cnt_r  <= q_cnt_r + CW'(e0_vld) + CW'(e1_vld) - CW'(out_pop);
    end
  end

  assign out_s.valid        = (q_cnt_r != '0);
  assign out_s.result_value = q_val_r[rd_ptr_r];
  assign out_s.result_col   = q_col_r[rd_ptr_r];
  assign out_s.result_row   = q_row_r[rd_ptr_r];
  assign out_s.frame_last   = q_last_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= CW'(DEPTH))
    else $error("result queue holds more words than it has entries");

  a_double_push: assert property (@(posedge clk) disable iff (!rst_n)
    (e0_vld && e1_vld && !out_pop) |=> (q_cnt_r == $past(q_cnt_r) + CW'(2)))
    else $error("last-row word did not queue both of its results");

  a_cfg_reread: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_s.ready)
    else $error("input taken before line store reread after a register write");
`endif

endmodule

@@ test/tb_curl_divergence_stencil.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the curl/divergence stencil, with directed frames and random traffic.
module tb_curl_divergence_stencil;
  import cds_pkg::*;

  localparam int SB           = DEF_SAMPLE_BITS;
  localparam int RB           = DEF_SAMPLE_BITS + 2;
  localparam int STORE_DEPTH  = DEF_MAX_WIDTH;
  localparam int RANDOM_WORDS = 1200;
  localparam int CALM_WORDS   = 150;
  localparam int STALL_LIMIT  = 1000;

  localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SAMPLE_MAX = ~SAMPLE_MIN;

  typedef struct packed {
    logic signed [SB-1:0] a;
    logic signed [SB-1:0] b;
  } sample_word_t;

  typedef struct packed {
    logic signed [RB-1:0] value;
    logic [COL_BITS-1:0]  col;
    logic [ROW_BITS-1:0]  row;
    logic                 last;
  } result_word_t;

  logic                     clk;
  logic                     rst_n;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  cds_in_if  in_bus ();
  cds_out_if out_bus ();

  curl_divergence_stencil dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_bus),
    .out_s   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic                 mode_reg;
  logic [FW_BITS-1:0]   width_reg;
  logic [FH_BITS-1:0]   height_reg;
  logic signed [SB-1:0] a_line [STORE_DEPTH];
  logic signed [SB-1:0] b_line [STORE_DEPTH];
  int                   col_cnt;
  int                   row_cnt;

  sample_word_t pending_samples[$];
  result_word_t expected_results[$];
  int           unaccepted;
  int           mismatch_count;
  int           idle_odds;
  int           in_gap;
  int           out_gap;
  int           quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_width(input int w);
    if (w < 1) return 1;
    if (w > STORE_DEPTH) return STORE_DEPTH;
    return w;
  endfunction

  function automatic int clamp_height(input int h);
    return (h < 1) ? 1 : h;
  endfunction

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      default: return SB'($urandom);
    endcase
  endfunction

  // Advances the stencil by one accepted word and queues the result words it produces.
  task automatic step_stencil(input sample_word_t s);
    int w;
    int h;
    int x;
    int y;
    logic signed [RB-1:0] v;
    w = clamp_width(width_reg);
    h = clamp_height(height_reg);
    x = (col_cnt > w - 1) ? w - 1 : col_cnt;
    y = (row_cnt > h - 1) ? h - 1 : row_cnt;
    if (y > 0) begin
      if (x == w - 1) begin
        v = a_line[x];
      end else if (mode_reg == MODE_CURL) begin
        v = (b_line[x] - b_line[x+1]) - (a_line[x] - s.a);
      end else begin
        v = (a_line[x] - a_line[x+1]) + (b_line[x] - s.b);
      end
      expected_results.push_back('{value: v, col: COL_BITS'(x), row: ROW_BITS'(y - 1),
                                   last: 1'b0});
    end
    a_line[x] = s.a;
    b_line[x] = s.b;
    if (y == h - 1) begin
      v = s.a;
      expected_results.push_back('{value: v, col: COL_BITS'(x), row: ROW_BITS'(y),
                                   last: (x == w - 1)});
    end
    if (x == w - 1) begin
      col_cnt = 0;
      row_cnt = (y == h - 1) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
      row_cnt = y;
    end
  endtask

  task automatic send_sample(input logic signed [SB-1:0] a_val, input logic signed [SB-1:0] b_val);
    pending_samples.push_back('{a: a_val, b: b_val});
    unaccepted++;
  endtask

  task automatic wait_idle(input int settle_cycles);
    while (unaccepted != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (settle_cycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   mode_reg = value[0];
      REG_WIDTH:  width_reg = value[FW_BITS-1:0];
      REG_HEIGHT: height_reg = value[FH_BITS-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : drive_samples
    sample_word_t word;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        step_stencil('{a: in_bus.a_value, b: in_bus.b_value});
        unaccepted--;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
          in_gap = $urandom_range(0, 15);
          in_bus.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          word = pending_samples.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.a_value <= word.a;
          in_bus.b_value <= word.b;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_word_t seen;
    result_word_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen = '{value: out_bus.result_value, col: out_bus.result_col,
                 row: out_bus.result_row, last: out_bus.frame_last};
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected word: value %0d col %0d row %0d last %0b",
                     seen.value, seen.col, seen.row, seen.last);
        end else begin
          want = expected_results.pop_front();
          if (seen.value !== want.value || seen.col !== want.col ||
              seen.row !== want.row || seen.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: expected value %0d col %0d row %0d last %0b, got value %0d col %0d row %0d last %0b",
                       want.value, want.col, want.row, want.last,
                       seen.value, seen.col, seen.row, seen.last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_odds > 0 && $urandom_range(1, idle_odds) == 1) begin
        out_gap = $urandom_range(0, 15);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run_test
    int sent;
    int w_pick;
    int h_pick;
    int w;
    int h;
    int x;
    int y;
    int remaining;
    int n;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_bus.valid   = 1'b0;
    in_bus.a_value = '0;
    in_bus.b_value = '0;
    out_bus.ready  = 1'b0;
    mode_reg       = MODE_CURL;
    width_reg      = FW_RESET;
    height_reg     = FH_RESET;
    col_cnt        = 0;
    row_cnt        = 0;
    unaccepted     = 0;
    mismatch_count = 0;
    idle_odds      = 4;
    quiet_cycles   = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two-by-two frames that drive curl and divergence to both ends of the result range.
    write_register(REG_MODE, MODE_CURL);
    write_register(REG_WIDTH, 2);
    write_register(REG_HEIGHT, 2);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(0, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, 0);
    send_sample(0, 0);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(0, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, 0);
    send_sample(0, 0);
    wait_idle(4);
    write_register(REG_MODE, MODE_DIV);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, 0);
    send_sample(0, SAMPLE_MIN);
    send_sample(0, 0);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, 0);
    send_sample(0, SAMPLE_MAX);
    send_sample(0, 0);
    wait_idle(4);

    // A zero width and a zero height both behave as one.
    write_register(REG_WIDTH, 0);
    write_register(REG_HEIGHT, 0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    wait_idle(4);

    // A width beyond the store depth is held at the depth; the frame is left open.
    write_register(REG_WIDTH, 2047);
    write_register(REG_HEIGHT, 1);
    send_sample(pick_sample(), pick_sample());
    send_sample(pick_sample(), pick_sample());
    wait_idle(4);

    // The column counter now lies past the last column.
    write_register(REG_WIDTH, 1);
    send_sample(pick_sample(), pick_sample());
    wait_idle(4);

    // The row counter now lies past the last row.
    write_register(REG_HEIGHT, 3);
    send_sample(pick_sample(), pick_sample());
    send_sample(pick_sample(), pick_sample());
    wait_idle(4);
    write_register(REG_HEIGHT, 2);
    send_sample(pick_sample(), pick_sample());
    wait_idle(4);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= RANDOM_WORDS - CALM_WORDS) begin
        idle_odds = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: idle_odds = 0;
          1: idle_odds = 3;
          2: idle_odds = 6;
          default: idle_odds = 16;
        endcase
      end
      write_register(REG_MODE, $urandom_range(0, 1) ? MODE_DIV : MODE_CURL);
      case ($urandom_range(0, 19))
        0: w_pick = 0;
        1: w_pick = 2047;
        2: w_pick = STORE_DEPTH;
        3: w_pick = $urandom_range(9, STORE_DEPTH - 1);
        default: w_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0: h_pick = 0;
        1: h_pick = 65535;
        2: h_pick = 1;
        default: h_pick = $urandom_range(2, 6);
      endcase
      // The stores only hold the current width, so a wider frame may start only on row zero.
      if (clamp_width(w_pick) <= clamp_width(width_reg) || row_cnt == 0)
        write_register(REG_WIDTH, w_pick);
      write_register(REG_HEIGHT, h_pick);

      w = clamp_width(width_reg);
      h = clamp_height(height_reg);
      x = (col_cnt > w - 1) ? w - 1 : col_cnt;
      y = (row_cnt > h - 1) ? h - 1 : row_cnt;
      remaining = (h - 1 - y) * w + (w - x);
      if (remaining > 300) begin
        n = $urandom_range(1, 60);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, remaining);
      end else begin
        n = remaining;
        if (w * h <= 100) n += $urandom_range(0, 2) * w * h;
      end
      repeat (n) send_sample(pick_sample(), pick_sample());
      sent += n;
      wait_idle(4);
    end

    wait_idle(8);
    if (mismatch_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
